// ===== rtl/mpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mpr_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int POS_W        = SAMPLE_W + 1;
	localparam int ARG_W        = 8;
	localparam int SUM_W        = 23;
	localparam int MAX_CHANNELS = 256;

	// one classified request on its way from the front to the back
	typedef struct packed {
		logic signed [POS_W-1:0] pair_sum;
		logic                    in_bounds;
		logic                    last_channel;
		logic                    last_position;
	} mpr_entry_t;

endpackage

`default_nettype wire

// ===== rtl/mpr_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mpr_item_if import mpr_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] input_value;
	logic signed [SAMPLE_W-1:0] weight_value;
	logic                       in_bounds;
	logic                       last_channel;
	logic                       last_position;

	modport source (
		output valid, input_value, weight_value, in_bounds, last_channel, last_position,
		input  ready
	);
	modport sink (
		input  valid, input_value, weight_value, in_bounds, last_channel, last_position,
		output ready
	);
endinterface

interface mpr_result_if import mpr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] position_max;
	logic        [ARG_W-1:0] argmax_channel;
	logic signed [SUM_W-1:0] patch_sum;
	logic                    patch_done;

	modport source (
		output valid, position_max, argmax_channel, patch_sum, patch_done,
		input  ready
	);
	modport sink (
		input  valid, position_max, argmax_channel, patch_sum, patch_done,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/mpr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mpr_front import mpr_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mpr_item_if.sink    items,
	output mpr_entry_t  push_data,
	output logic        push_valid,
	input  wire logic   push_ready
);

	logic       valid_s1;
	mpr_entry_t entry_s1;
	mpr_entry_t entry_d;

	always_comb begin
		entry_d.pair_sum      = $signed({items.input_value[SAMPLE_W-1], items.input_value})
		                      + $signed({items.weight_value[SAMPLE_W-1], items.weight_value});
		entry_d.in_bounds     = items.in_bounds;
		entry_d.last_channel  = items.last_channel;
		entry_d.last_position = items.last_position;
	end

	assign items.ready = !valid_s1 || push_ready;
	assign push_valid  = valid_s1;
	assign push_data   = entry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			entry_s1 <= entry_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/mpr_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mpr_queue import mpr_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push_valid,
	output logic             push_ready,
	input  wire mpr_entry_t  push_data,
	output logic             pop_valid,
	input  wire logic        pop_ready,
	output mpr_entry_t       pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	mpr_entry_t             entries_q [DEPTH];
	logic       [PTR_W-1:0] wr_ptr_q;
	logic       [PTR_W-1:0] rd_ptr_q;
	logic       [CNT_W-1:0] count_q;
	logic                   push;
	logic                   pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
		else $error("queue empty with pointers apart");
`endif

endmodule

`default_nettype wire

// ===== rtl/mpr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mpr_back import mpr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  wire mpr_entry_t  head,
	output logic             head_pop,
	mpr_result_if.source     results
);

	localparam int CNT_W = ARG_W + 1;

	logic signed [POS_W-1:0] run_max_q;
	logic        [ARG_W-1:0] run_arg_q;
	logic        [ARG_W-1:0] chan_cnt_q;
	logic                    first_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    out_valid_q;

	logic                    emits;
	logic                    take;
	logic signed [POS_W-1:0] new_max;
	logic        [ARG_W-1:0] new_arg;
	logic        [CNT_W-1:0] cnt_inc;
	logic        [ARG_W-1:0] cnt_next;
	logic signed [POS_W-1:0] pmax;
	logic        [ARG_W-1:0] parg;
	logic signed [SUM_W:0]   sum_wide;
	logic signed [SUM_W-1:0] sum_sat;

	// padded requests always close their position
	assign emits    = !head.in_bounds || head.last_channel;
	assign head_pop = head_valid && (!emits || !out_valid_q || results.ready);

	always_comb begin
		take     = first_q || ($signed(head.pair_sum) > run_max_q);
		new_max  = take ? head.pair_sum : run_max_q;
		new_arg  = take ? chan_cnt_q : run_arg_q;
		cnt_inc  = {1'b0, chan_cnt_q} + 1'b1;
		cnt_next = (32'(cnt_inc) >= 32'(MAX_CHANNELS)) ? '0 : cnt_inc[ARG_W-1:0];
		pmax     = head.in_bounds ? new_max : '0;
		parg     = head.in_bounds ? new_arg : '0;
		sum_wide = $signed({sum_q[SUM_W-1], sum_q}) + (SUM_W + 1)'(pmax);
		// clamp at the signed limits of the sum
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
			                          : {1'b0, {(SUM_W - 1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	assign results.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_max_q   <= '0;
			run_arg_q   <= '0;
			chan_cnt_q  <= '0;
			first_q     <= 1'b1;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (head_pop && emits) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			if (head_pop) begin
				if (emits) begin
					run_max_q  <= '0;
					run_arg_q  <= '0;
					chan_cnt_q <= '0;
					first_q    <= 1'b1;
					sum_q      <= head.last_position ? '0 : sum_sat;
				end else begin
					run_max_q  <= new_max;
					run_arg_q  <= new_arg;
					chan_cnt_q <= cnt_next;
					first_q    <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (head_pop && emits) begin
			results.position_max   <= pmax;
			results.argmax_channel <= parg;
			results.patch_sum      <= head.last_position ? sum_sat : '0;
			results.patch_done     <= head.last_position;
		end
	end

`ifndef ASSERT_OFF
	a_sum_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.patch_done) |-> (results.patch_sum == '0))
		else $error("patch sum shown on a position that does not end the patch");
	a_padded_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(head_pop && !head.in_bounds) |=>
		(out_valid_q && results.position_max == '0 && results.argmax_channel == '0))
		else $error("padded position gave a nonzero result");
`endif

endmodule

`default_nettype wire

// ===== rtl/max_plus_patch_reduce.sv =====
// path: front register, queue slot, then output register, for each closing request
// throughput: one request per cycle while results are taken; the running max,
//   counter and patch sum update per request; the front/back queue absorbs stalls
// reset: arst_n asynchronous, active low; clears running max, argmax, channel
//   counter, patch sum, queue pointers and valid flags; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module max_plus_patch_reduce import mpr_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	mpr_item_if.sink      items,
	mpr_result_if.source  results
);

	mpr_entry_t push_data;
	logic       push_valid;
	logic       push_ready;
	mpr_entry_t head;
	logic       head_valid;
	logic       head_pop;

	mpr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	mpr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (head_valid),
		.pop_ready  (head_pop),
		.pop_data   (head)
	);

	mpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_pop   (head_pop),
		.results    (results)
	);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import mpr_pkg::*;

	localparam int SUM_HI = (1 << (SUM_W - 1)) - 1;
	localparam int SUM_LO = -(1 << (SUM_W - 1));
	localparam int RANDOM_ITEMS = 1750;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] input_value;
		logic signed [SAMPLE_W-1:0] weight_value;
		logic                       in_bounds;
		logic                       last_channel;
		logic                       last_position;
	} sample_req_t;

	typedef struct packed {
		logic signed [POS_W-1:0] position_max;
		logic        [ARG_W-1:0] argmax_channel;
		logic signed [SUM_W-1:0] patch_sum;
		logic                    patch_done;
	} reduce_res_t;

	logic clk = 1'b0;
	logic arst_n;

	mpr_item_if   items_if ();
	mpr_result_if results_if ();

	max_plus_patch_reduce u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.results (results_if)
	);

	always #2 clk = ~clk;

	sample_req_t pending_items[$];
	reduce_res_t expected_results[$];
	int          mismatch_count = 0;
	int          results_checked;

	// shadow of the block's reduction state
	logic signed [POS_W-1:0] best_value;
	logic        [ARG_W-1:0] best_channel;
	int                      channel_idx;
	bit                      fresh_position;
	int                      patch_total;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// fold one accepted request into the running max and queue the result it causes
	task automatic apply_max_plus(input sample_req_t req);
		logic signed [POS_W-1:0] pair;
		reduce_res_t res;
		res = '0;
		if (req.in_bounds) begin
			pair = req.input_value + req.weight_value;
			if (fresh_position || pair > best_value) begin
				best_value   = pair;
				best_channel = channel_idx[ARG_W-1:0];
			end
			fresh_position = 1'b0;
			if (channel_idx + 1 >= MAX_CHANNELS)
				channel_idx = 0;
			else
				channel_idx = channel_idx + 1;
			if (!req.last_channel)
				return;
			res.position_max   = best_value;
			res.argmax_channel = best_channel;
		end
		best_value     = '0;
		best_channel   = '0;
		channel_idx    = 0;
		fresh_position = 1'b1;
		patch_total = patch_total + int'(res.position_max);
		if (patch_total > SUM_HI)
			patch_total = SUM_HI;
		if (patch_total < SUM_LO)
			patch_total = SUM_LO;
		if (req.last_position) begin
			res.patch_sum  = patch_total[SUM_W-1:0];
			res.patch_done = 1'b1;
			patch_total    = 0;
		end
		expected_results.push_back(res);
	endtask

	task automatic push_item(input int a, input int b, input bit inb, input bit lc, input bit lp);
		sample_req_t req;
		req.input_value   = a[SAMPLE_W-1:0];
		req.weight_value  = b[SAMPLE_W-1:0];
		req.in_bounds     = inb;
		req.last_channel  = lc;
		req.last_position = lp;
		pending_items.push_back(req);
	endtask

	function automatic int pick_sample(input int flavor);
		case (flavor)
			0: pick_sample = int'($urandom);
			1: pick_sample = $urandom_range(0, 3);
			2: pick_sample = int'($urandom_range(0, 255)) - 32768;
			default: begin
				case ($urandom_range(0, 3))
					0: pick_sample = -32768;
					1: pick_sample = -1;
					2: pick_sample = 0;
					default: pick_sample = 32767;
				endcase
			end
		endcase
	endfunction

	// one in-bounds kernel position; a peak channel, if given, holds the clear maximum
	task automatic add_position(input int channels, input bit lp, input int flavor,
		input int peak_at);
		for (int c = 0; c < channels; c++) begin
			if (c == peak_at)
				push_item(32767, 32767, 1'b1, c == channels - 1, lp);
			else
				push_item(pick_sample(flavor), pick_sample(flavor), 1'b1, c == channels - 1, lp);
		end
	endtask

	// sender: bursts of requests with random gaps
	sample_req_t next_item;
	int unsigned burst_left;
	int unsigned gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_if.valid         <= 1'b0;
			items_if.input_value   <= '0;
			items_if.weight_value  <= '0;
			items_if.in_bounds     <= 1'b0;
			items_if.last_channel  <= 1'b0;
			items_if.last_position <= 1'b0;
			burst_left             <= 0;
			gap_left               <= 0;
		end else begin
			if (items_if.valid && items_if.ready)
				apply_max_plus('{input_value: items_if.input_value,
					weight_value: items_if.weight_value, in_bounds: items_if.in_bounds,
					last_channel: items_if.last_channel,
					last_position: items_if.last_position});
			if (!items_if.valid || items_if.ready) begin
				if (gap_left != 0) begin
					gap_left       <= gap_left - 1;
					items_if.valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					next_item = pending_items.pop_front();
					items_if.valid         <= 1'b1;
					items_if.input_value   <= next_item.input_value;
					items_if.weight_value  <= next_item.weight_value;
					items_if.in_bounds     <= next_item.in_bounds;
					items_if.last_channel  <= next_item.last_channel;
					items_if.last_position <= next_item.last_position;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					items_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern that cycles through four modes, plus one long hold-off
	int unsigned stall_cycle;
	int unsigned holdoff_left;
	bit          holdoff_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			stall_cycle      <= 0;
			holdoff_left     <= 0;
			holdoff_done     <= 1'b0;
		end else begin
			stall_cycle <= stall_cycle + 1;
			if (holdoff_left != 0) begin
				holdoff_left     <= holdoff_left - 1;
				results_if.ready <= 1'b0;
			end else if (!holdoff_done && results_checked >= 200) begin
				holdoff_done     <= 1'b1;
				holdoff_left     <= 400;
				results_if.ready <= 1'b0;
			end else begin
				case ((stall_cycle / 512) % 4)
					0: results_if.ready <= 1'b1;
					1: results_if.ready <= ($urandom_range(0, 3) != 0);
					2: results_if.ready <= ((stall_cycle % 7) < 3);
					default: results_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// monitor
	reduce_res_t want;

	always @(posedge clk) begin
		if (arst_n === 1'b1 && results_if.valid && results_if.ready) begin
			results_checked <= results_checked + 1;
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result max=%0d arg=%0d sum=%0d done=%0b",
					results_if.position_max, results_if.argmax_channel,
					results_if.patch_sum, results_if.patch_done));
			end else begin
				want = expected_results.pop_front();
				if (results_if.position_max !== want.position_max)
					report_mismatch($sformatf("position_max got %0d want %0d",
						results_if.position_max, want.position_max));
				if (results_if.argmax_channel !== want.argmax_channel)
					report_mismatch($sformatf("argmax_channel got %0d want %0d",
						results_if.argmax_channel, want.argmax_channel));
				if (results_if.patch_sum !== want.patch_sum)
					report_mismatch($sformatf("patch_sum got %0d want %0d",
						results_if.patch_sum, want.patch_sum));
				if (results_if.patch_done !== want.patch_done)
					report_mismatch($sformatf("patch_done got %0b want %0b",
						results_if.patch_done, want.patch_done));
			end
		end
	end

	initial begin
		int patch_no;
		int npos;
		int channels;
		int drain;
		int level;
		bit upward;

		arst_n                 = 1'b0;
		items_if.valid         = 1'b0;
		items_if.input_value   = '0;
		items_if.weight_value  = '0;
		items_if.in_bounds     = 1'b0;
		items_if.last_channel  = 1'b0;
		items_if.last_position = 1'b0;
		results_if.ready       = 1'b0;
		results_checked        = 0;
		best_value             = '0;
		best_channel           = '0;
		channel_idx            = 0;
		fresh_position         = 1'b1;
		patch_total            = 0;

		// padded request on its own
		push_item(1234, -77, 1'b0, 1'b0, 1'b0);
		// largest and smallest pair sums
		push_item(32767, 32767, 1'b1, 1'b1, 1'b0);
		push_item(-32768, -32768, 1'b1, 1'b1, 1'b1);
		// ties keep the earliest channel
		push_item(5, 5, 1'b1, 1'b0, 1'b0);
		push_item(10, 0, 1'b1, 1'b0, 1'b0);
		push_item(3, 7, 1'b1, 1'b1, 1'b0);
		push_item(1, 1, 1'b1, 1'b0, 1'b0);
		push_item(2, 2, 1'b1, 1'b0, 1'b0);
		push_item(2, 2, 1'b1, 1'b1, 1'b0);
		// padded request cuts off a partial channel run
		push_item(100, 100, 1'b1, 1'b0, 1'b0);
		push_item(-1, -1, 1'b0, 1'b1, 1'b0);
		// negative first channel still becomes the max
		push_item(-5, -3, 1'b1, 1'b1, 1'b0);
		// last_position on a non-final channel is ignored
		push_item(1, 2, 1'b1, 1'b0, 1'b1);
		push_item(3, 4, 1'b1, 1'b1, 1'b1);
		// padded position closing a patch
		push_item(-32768, 32767, 1'b0, 1'b0, 1'b1);
		push_item(-32768, 32767, 1'b1, 1'b0, 1'b0);
		push_item(32767, -32768, 1'b1, 1'b1, 1'b1);
		push_item(0, 0, 1'b1, 1'b1, 1'b1);

		patch_no = 0;
		while (pending_items.size() < RANDOM_ITEMS) begin
			patch_no++;
			if (patch_no % 40 == 15) begin
				// more than 256 channels: counter and argmax wrap
				channels = $urandom_range(257, 300);
				add_position(channels, 1'b1, 1,
					$urandom_range(0, 1) ? 255 : $urandom_range(256, channels - 1));
			end else if (patch_no % 40 == 35) begin
				// more positions than the sum is sized for: saturates
				npos   = $urandom_range(66, 80);
				upward = $urandom_range(0, 1);
				for (int p = 0; p < npos; p++) begin
					level = $urandom_range(0, 40);
					if (upward)
						push_item(32767 - level, 32767, 1'b1, 1'b1, p == npos - 1);
					else
						push_item(-32768 + level, -32768, 1'b1, 1'b1, p == npos - 1);
				end
			end else begin
				npos = $urandom_range(1, 8);
				for (int p = 0; p < npos; p++) begin
					if ($urandom_range(0, 9) == 0)
						push_item(int'($urandom), int'($urandom), $urandom_range(0, 1),
							$urandom_range(0, 1), $urandom_range(0, 1));
					else if ($urandom_range(0, 4) == 0)
						push_item(int'($urandom), int'($urandom), 1'b0, $urandom_range(0, 1),
							p == npos - 1);
					else
						add_position($urandom_range(1, 6), p == npos - 1,
							$urandom_range(0, 3), -1);
				end
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || items_if.valid)
			@(posedge clk);
		drain = 0;
		while (expected_results.size() != 0 && drain < 5000) begin
			@(posedge clk);
			drain++;
		end
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/mpr_pkg.sv
rtl/mpr_ifs.sv
rtl/mpr_front.sv
rtl/mpr_queue.sv
rtl/mpr_back.sv
rtl/max_plus_patch_reduce.sv
tb/tb.sv
